@@ sv/esd_pkg.sv @@
// Shared types and character constants for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } esd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } esd_out_t;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerV    = 8'h76;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerA    = 8'h61;

  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlHt  = 8'h09;
  localparam logic [7:0] CtlVt  = 8'h0B;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlBel = 8'h07;

endpackage

`default_nettype wire

@@ sv/escape_sequence_decoder_top.sv @@
// Escape sequence decoder: turns C-style escapes in a byte stream into plain bytes.
//
// The input channel (in_valid_i / in_ready_o / in_data_i) takes one raw
// character per request, with in_last marking the end of a string. The
// output channel (out_valid_o / out_ready_i / out_data_o) gives decoded
// bytes; out_last marks the final decoded byte of a string.
// Each accepted character is decoded in the cycle it arrives and its
// results land in a two-entry result register, so the first result is
// visible in the cycle after acceptance. Characters that yield zero or one
// result are taken at one per cycle while the receiver keeps up. An unknown
// escape, or a hex escape closed by an ordinary character, yields two results
// and refuses the input until only the second one is left to drain.
// When the receiver stalls, the result register holds and the input is
// refused until there is room again; a new character is still taken while
// the last pending result is being delivered.
// Reset clears the escape state and drops any pending results.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire esd_pkg::esd_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output esd_pkg::esd_out_t     out_data_o
);

  localparam logic [1:0] PhNormal = 2'd0;
  localparam logic [1:0] PhBslash = 2'd1;
  localparam logic [1:0] PhHex0   = 2'd2;
  localparam logic [1:0] PhHex1   = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [3:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;
  esd_pkg::esd_out_t res0_q, res0_d, res1_q, res1_d;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       last;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       simple_ok;
  logic [7:0] simple_val;
  logic       plain;
  logic [1:0] n;
  logic [7:0] b0, b1;

  assign b    = in_data_i.in_byte;
  assign last = in_data_i.in_last;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = res0_q;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    simple_ok  = 1'b1;
    simple_val = b;
    unique case (b)
      esd_pkg::ChLowerN:    simple_val = esd_pkg::CtlLf;
      esd_pkg::ChLowerT:    simple_val = esd_pkg::CtlHt;
      esd_pkg::ChLowerV:    simple_val = esd_pkg::CtlVt;
      esd_pkg::ChLowerB:    simple_val = esd_pkg::CtlBs;
      esd_pkg::ChLowerR:    simple_val = esd_pkg::CtlCr;
      esd_pkg::ChLowerF:    simple_val = esd_pkg::CtlFf;
      esd_pkg::ChLowerA:    simple_val = esd_pkg::CtlBel;
      esd_pkg::ChBackslash,
      esd_pkg::ChQuestion,
      esd_pkg::ChQuote,
      esd_pkg::ChDquote:    simple_val = b;
      default:              simple_ok  = 1'b0;
    endcase
  end

  // Decode one character into up to two result bytes and the next state.
  always_comb begin
    n       = 2'd0;
    b0      = 8'd0;
    b1      = 8'd0;
    phase_d = phase_q;
    acc_d   = acc_q;
    plain   = 1'b0;
    unique case (phase_q)
      PhHex0, PhHex1: begin
        if (hex_ok) begin
          if (phase_q == PhHex0) begin
            phase_d = PhHex1;
            acc_d   = hex_val;
            if (last) begin
              n  = 2'd1;
              b0 = {4'd0, hex_val};
            end
          end else begin
            n       = 2'd1;
            b0      = {acc_q, hex_val};
            phase_d = PhNormal;
          end
        end else begin
          // The pending hex value goes out first, then the byte is decoded as plain text.
          n     = 2'd1;
          b0    = (phase_q == PhHex1) ? {4'd0, acc_q} : 8'd0;
          plain = 1'b1;
        end
      end
      PhBslash: begin
        if (b == esd_pkg::ChLowerX) begin
          phase_d = PhHex0;
          acc_d   = 4'd0;
          if (last) begin
            n  = 2'd1;
            b0 = 8'd0;
          end
        end else if (simple_ok) begin
          n       = 2'd1;
          b0      = simple_val;
          phase_d = PhNormal;
        end else begin
          n       = 2'd2;
          b0      = esd_pkg::ChBackslash;
          b1      = b;
          phase_d = PhNormal;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      if (b == esd_pkg::ChBackslash) begin
        phase_d = PhBslash;
        if (last) begin
          if (n == 2'd0) b0 = b;
          else b1 = b;
          n = n + 2'd1;
        end
      end else begin
        phase_d = PhNormal;
        if (n == 2'd0) b0 = b;
        else b1 = b;
        n = n + 2'd1;
      end
    end

    if (last) begin
      phase_d = PhNormal;
      acc_d   = 4'd0;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    res0_d = res0_q;
    res1_d = res1_q;
    if (in_fire) begin
      cnt_d           = n;
      res0_d.out_byte = b0;
      res0_d.out_last = last && (n == 2'd1);
      res1_d.out_byte = b1;
      res1_d.out_last = last;
    end else if (out_fire) begin
      cnt_d  = cnt_q - 2'd1;
      res0_d = res1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      acc_q   <= 4'd0;
      cnt_q   <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

endmodule

`default_nettype wire

@@ sv/esd_checker.sv @@
// Port-level checks for the escape sequence decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module esd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire esd_pkg::esd_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire esd_pkg::esd_out_t out_data_o
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Every request yields a result or sets up an escape, so the block is busy next cycle
  // only if it had something to show; every string end shows a result.
  a_last_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.in_last |=> out_valid_o)
    else $error("string end produced no result");

  // The input is only refused while results are pending.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input refused with nothing pending");

endmodule

bind escape_sequence_decoder_top esd_checker u_esd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ dv/escape_sequence_decoder_top_tb.sv @@
// Self-checking testbench for the escape sequence decoder with a scoreboard predictor.
`timescale 1ns / 1ps

module escape_sequence_decoder_top_tb;
  import esd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;

  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerQ = 8'h71;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  typedef enum logic [1:0] {
    PhPlain,
    PhAfterSlash,
    PhHexNone,
    PhHexOne
  } esc_phase_e;

  class decoded_byte_sb;
    esc_phase_e  esc_phase;
    logic [3:0]  hex_high;
    esd_out_t    expected_bytes[$];
    int unsigned failures;

    function new();
      esc_phase = PhPlain;
      hex_high  = '0;
      failures  = 0;
    endfunction

    function int hex_value_of(logic [7:0] c);
      if (c >= ChDigit0 && c <= ChDigit9) return int'(c - ChDigit0);
      if (c >= ChLowerA && c <= ChLowerF) return int'(c - ChLowerA) + 10;
      if (c >= ChUpperA && c <= ChUpperF) return int'(c - ChUpperA) + 10;
      return -1;
    endfunction

    function int escaped_value_of(logic [7:0] c);
      case (c)
        ChLowerN:    return int'(CtlLf);
        ChLowerT:    return int'(CtlHt);
        ChLowerV:    return int'(CtlVt);
        ChLowerB:    return int'(CtlBs);
        ChLowerR:    return int'(CtlCr);
        ChLowerF:    return int'(CtlFf);
        ChLowerA:    return int'(CtlBel);
        ChBackslash: return int'(ChBackslash);
        ChQuestion:  return int'(ChQuestion);
        ChQuote:     return int'(ChQuote);
        ChDquote:    return int'(ChDquote);
        default:     return -1;
      endcase
    endfunction

    function void push_decoded(logic [7:0] value);
      esd_out_t res;
      res.out_byte = value;
      res.out_last = 1'b0;
      expected_bytes.push_back(res);
    endfunction

    // Works out the decoded bytes caused by one accepted request.
    function void predict_from_char(esd_in_t req);
      logic [7:0] c;
      int         digit;
      int         mapped;
      int         first_new;
      bit         taken;
      c         = req.in_byte;
      first_new = expected_bytes.size();
      taken     = 1'b0;

      if (esc_phase == PhHexNone || esc_phase == PhHexOne) begin
        digit = hex_value_of(c);
        if (digit >= 0) begin
          if (esc_phase == PhHexNone) begin
            hex_high  = digit[3:0];
            esc_phase = PhHexOne;
            if (req.in_last) push_decoded({4'h0, hex_high});
          end else begin
            push_decoded({hex_high, digit[3:0]});
            esc_phase = PhPlain;
          end
          taken = 1'b1;
        end else begin
          // A non-hex character closes the hex escape and is then decoded on its own.
          push_decoded(esc_phase == PhHexOne ? {4'h0, hex_high} : 8'h00);
          esc_phase = PhPlain;
        end
      end

      if (!taken && esc_phase == PhAfterSlash) begin
        mapped = escaped_value_of(c);
        if (c == ChLowerX) begin
          esc_phase = PhHexNone;
          hex_high  = '0;
          if (req.in_last) push_decoded(8'h00);
        end else if (mapped >= 0) begin
          push_decoded(mapped[7:0]);
          esc_phase = PhPlain;
        end else begin
          push_decoded(ChBackslash);
          push_decoded(c);
          esc_phase = PhPlain;
        end
        taken = 1'b1;
      end

      if (!taken) begin
        if (c == ChBackslash) begin
          esc_phase = PhAfterSlash;
          if (req.in_last) push_decoded(ChBackslash);
        end else begin
          push_decoded(c);
          esc_phase = PhPlain;
        end
      end

      if (req.in_last) begin
        if (expected_bytes.size() > first_new) begin
          expected_bytes[expected_bytes.size() - 1].out_last = 1'b1;
        end
        esc_phase = PhPlain;
        hex_high  = '0;
      end
    endfunction

    function void compare_decoded(esd_out_t got);
      esd_out_t want;
      if (expected_bytes.size() == 0) begin
        if (failures < ReportLimit) begin
          $display("unexpected result: byte=%02h last=%0b", got.out_byte, got.out_last);
        end
        failures++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.out_last !== want.out_last) begin
        if (failures < ReportLimit) begin
          $display("mismatch: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                   want.out_byte, want.out_last, got.out_byte, got.out_last);
        end
        failures++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  esd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  esd_out_t out_data_o;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 46;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  logic [7:0]  text_q[$];

  decoded_byte_sb decoded_sb = new();

  escape_sequence_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) decoded_sb.compare_decoded(out_data_o);
  end

  task automatic send_request(esd_in_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    decoded_sb.predict_from_char(req);
  endtask

  task automatic send_text();
    esd_in_t req;
    for (int i = 0; i < text_q.size(); i++) begin
      req.in_byte = text_q[i];
      req.in_last = (i == text_q.size() - 1);
      send_request(req);
      items_sent++;
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Simple and hex escapes with random content, mixed with printable and random
  // bytes, arbitrary escapes and lone backslashes that break sequences.
  function automatic void build_random_text();
    int pieces;
    int ndigits;
    int val;
    pieces = $urandom_range(6, 1);
    text_q.delete();
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(9))
        0, 1: text_q.push_back(8'($urandom_range(8'h7E, 8'h20)));
        2, 3: begin
          text_q.push_back(ChBackslash);
          case ($urandom_range(10))
            0:       text_q.push_back(ChLowerN);
            1:       text_q.push_back(ChLowerT);
            2:       text_q.push_back(ChLowerV);
            3:       text_q.push_back(ChLowerB);
            4:       text_q.push_back(ChLowerR);
            5:       text_q.push_back(ChLowerF);
            6:       text_q.push_back(ChLowerA);
            7:       text_q.push_back(ChBackslash);
            8:       text_q.push_back(ChQuestion);
            9:       text_q.push_back(ChQuote);
            default: text_q.push_back(ChDquote);
          endcase
        end
        4, 5: begin
          text_q.push_back(ChBackslash);
          text_q.push_back(ChLowerX);
          ndigits = $urandom_range(2);
          for (int d = 0; d < ndigits; d++) begin
            val = $urandom_range(15);
            if (val < 10) text_q.push_back(ChDigit0 + 8'(val));
            else if ($urandom_range(1) == 0) text_q.push_back(ChLowerA + 8'(val - 10));
            else text_q.push_back(ChUpperA + 8'(val - 10));
          end
        end
        6: begin
          text_q.push_back(ChBackslash);
          text_q.push_back(8'($urandom_range(255)));
        end
        7: text_q.push_back(ChBackslash);
        8: text_q.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        default: text_q.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  initial begin
    int unsigned target;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    text_q = '{8'h00, 8'hFF};
    send_text();
    text_q = '{ChBackslash, ChLowerN, ChBackslash, ChBackslash};
    send_text();
    // Unknown escape, two-digit hex, and hex closed by a new escape.
    text_q = '{ChBackslash, ChLowerQ, ChBackslash, ChLowerX, ChDigit0 + 8'd4, ChLowerF,
               ChBackslash, ChLowerX, ChUpperA, ChBackslash, ChDquote};
    send_text();
    text_q = '{ChBackslash, ChLowerX, ChLowerZ};
    send_text();
    text_q = '{ChBackslash};
    send_text();
    text_q = '{ChBackslash, ChLowerX};
    send_text();
    text_q = '{ChBackslash, ChLowerX, ChDigit0 + 8'd3};
    send_text();

    target = items_sent + 150;
    while (items_sent < target) begin
      build_random_text();
      send_text();
    end
    pause_until_drained();

    send_idle_pct = 46;
    recv_idle_pct = 34;
    target = items_sent + 150;
    while (items_sent < target) begin
      build_random_text();
      send_text();
    end
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = items_sent + 150;
    while (items_sent < target) begin
      build_random_text();
      send_text();
    end
    pause_until_drained();
    repeat (20) @(posedge clk_i);

    if (decoded_sb.pending() != 0) begin
      $display("%0d expected results never arrived", decoded_sb.pending());
      decoded_sb.failures++;
    end
    if (decoded_sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
